@@ design/assert_macros.svh @@
// Assertion macros shared by the gate generator RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check: expr holds at every sampled edge.
`define SVPG_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication check: cons holds at every edge where ante holds.
`define SVPG_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ design/svpg_pkg.sv @@
// Shared types and constants for the space vector PWM gate generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package svpg_pkg;

	// configuration register indexes
	localparam logic REG_VDC = 1'b0;
	localparam logic REG_TS  = 1'b1;

	// hexagon sectors
	localparam logic [2:0] SECT_0 = 3'd0;
	localparam logic [2:0] SECT_1 = 3'd1;
	localparam logic [2:0] SECT_2 = 3'd2;
	localparam logic [2:0] SECT_3 = 3'd3;
	localparam logic [2:0] SECT_4 = 3'd4;
	localparam logic [2:0] SECT_5 = 3'd5;

	// sideband that rides along the time pipeline
	typedef struct packed {
		logic [2:0]  sector;
		logic [15:0] carrier;
	} side_t;

	// round(sqrt(3) * 2^f), bitwise integer square root of 3 * 4^f
	function automatic longint unsigned sqrt3_fixed(input int unsigned f);
		longint unsigned n;
		longint unsigned r;
		longint unsigned b;
		begin
			n = 64'd3 << (2 * f);
			r = 64'd0;
			b = 64'h4000_0000_0000_0000;
			while (b > n) b = b >> 2;
			while (b != 64'd0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			if (n > r) r = r + 64'd1;
			return r;
		end
	endfunction

endpackage

`default_nettype wire

@@ design/svpg_front.sv @@
// Front end: sqrt(3) products, sector decision, X/Y/Z numerators, times Ts.
// Three pipeline stages; depends on svpg_pkg.
`default_nettype none

module svpg_front #(
	parameter int W = 16,
	parameter int F = 14
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_vld,
	input  wire logic signed [W-1:0]  alpha,
	input  wire logic signed [W-1:0]  beta,
	input  wire logic [15:0]          carrier,
	input  wire logic [15:0]          ts,
	output logic                      out_vld,
	output logic signed [W+19:0]      num_a,
	output logic signed [W+19:0]      num_b,
	output svpg_pkg::side_t           side
);
	import svpg_pkg::*;

	localparam int NW = W + F + 4;
	localparam int PW = NW + 17;
	localparam longint unsigned SQRT3_L = sqrt3_fixed(F);
	localparam logic [F:0] SQRT3 = SQRT3_L[F:0];
	localparam int MW = W + F + 2;

	// stage 1: the two sqrt(3) products
	logic signed [MW-1:0] p_c, sb_c;
	logic signed [MW-1:0] p_s1, sb_s1;
	logic signed [W-1:0]  alpha_s1, beta_s1;
	logic [15:0]          carrier_s1;
	logic                 vld_s1;

	assign p_c  = $signed({1'b0, SQRT3}) * alpha;
	assign sb_c = $signed({1'b0, SQRT3}) * beta;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1       <= p_c;
			sb_s1      <= sb_c;
			alpha_s1   <= alpha;
			beta_s1    <= beta;
			carrier_s1 <= carrier;
		end
	end

	// stage 2: sector and selected numerators
	logic signed [MW-1:0] b_c, np_c;
	logic                 bge, ble, age, alt, ale, agt;
	logic [2:0]           sector_c;
	logic signed [NW-1:0] a_e, a3f_c, sb_e, xn_c, yn_c, zn_c, tan_c, tbn_c;
	logic signed [NW-1:0] tan_s2, tbn_s2;
	side_t                side_s2;
	logic                 vld_s2;

	assign b_c  = {{2{beta_s1[W-1]}}, beta_s1, {F{1'b0}}};
	assign np_c = -p_s1;
	assign bge  = !beta_s1[W-1];
	assign ble  = beta_s1[W-1] || (beta_s1 == '0);
	assign age  = !alpha_s1[W-1];
	assign alt  = alpha_s1[W-1];
	assign ale  = alpha_s1[W-1] || (alpha_s1 == '0);
	assign agt  = !alpha_s1[W-1] && (alpha_s1 != '0);

	always_comb begin
		sector_c = SECT_5;
		if (bge && b_c <= p_s1)
			sector_c = SECT_0;
		else if (bge && ((age && b_c >= p_s1) || (alt && b_c >= np_c)))
			sector_c = SECT_1;
		else if (bge && b_c <= np_c)
			sector_c = SECT_2;
		else if (ble && b_c >= p_s1)
			sector_c = SECT_3;
		else if (ble && ((ale && b_c <= p_s1) || (agt && b_c <= np_c)))
			sector_c = SECT_4;
	end

	assign a_e   = NW'(alpha_s1);
	assign sb_e  = NW'(sb_s1);
	assign a3f_c = (a_e + (a_e <<< 1)) <<< F;
	assign xn_c  = sb_e <<< 1;
	assign yn_c  = a3f_c + sb_e;
	assign zn_c  = sb_e - a3f_c;

	always_comb begin
		case (sector_c)
			SECT_0:  begin tan_c = -zn_c; tbn_c = xn_c;  end
			SECT_1:  begin tan_c = yn_c;  tbn_c = zn_c;  end
			SECT_2:  begin tan_c = xn_c;  tbn_c = -yn_c; end
			SECT_3:  begin tan_c = zn_c;  tbn_c = -xn_c; end
			SECT_4:  begin tan_c = -yn_c; tbn_c = -zn_c; end
			default: begin tan_c = -xn_c; tbn_c = yn_c;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tan_s2          <= tan_c;
			tbn_s2          <= tbn_c;
			side_s2.sector  <= sector_c;
			side_s2.carrier <= carrier_s1;
		end
	end

	// stage 3: times Ts, then floor-shift by 2^(F+1)
	logic signed [PW-1:0] pa_c, pb_c;
	logic signed [W+19:0] na_s3, nb_s3;
	side_t                side_s3;
	logic                 vld_s3;

	assign pa_c = tan_s2 * $signed({1'b0, ts});
	assign pb_c = tbn_s2 * $signed({1'b0, ts});

	always_ff @(posedge clk) begin
		if (en) begin
			na_s3   <= pa_c[PW-1:F+1];
			nb_s3   <= pb_c[PW-1:F+1];
			side_s3 <= side_s2;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_vld = vld_s3;
	assign num_a   = na_s3;
	assign num_b   = nb_s3;
	assign side    = side_s3;

endmodule

`default_nettype wire

@@ design/svpg_div.sv @@
// Two-lane pipelined floor divider by the DC link voltage, one quotient bit per stage.
// Depends on svpg_pkg for the sideband type.
`default_nettype none

module svpg_div #(
	parameter int QW = 36
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic [15:0]          vdc,
	input  wire logic                 in_vld,
	input  wire logic signed [QW-1:0] num_a,
	input  wire logic signed [QW-1:0] num_b,
	input  svpg_pkg::side_t           in_side,
	output logic                      out_vld,
	output logic signed [QW:0]        t_a,
	output logic signed [QW:0]        t_b,
	output svpg_pkg::side_t           out_side
);
	import svpg_pkg::*;

	// index 0 is the magnitude stage, 1..QW the bit stages
	logic [QW-1:0] quo_s [QW+1][2];
	logic [15:0]   rem_s [QW+1][2];
	logic          neg_s [QW+1][2];
	side_t         side_s [QW+1];
	logic          vld_s [QW+2];

	logic signed [QW-1:0] num_in [2];
	assign num_in[0] = num_a;
	assign num_in[1] = num_b;

	// magnitude stage
	for (genvar l = 0; l < 2; l++) begin : g_abs
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[0][l] <= num_in[l][QW-1];
				quo_s[0][l] <= num_in[l][QW-1] ? QW'(-num_in[l]) : QW'(num_in[l]);
				rem_s[0][l] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) side_s[0] <= in_side;
	end

	// restoring division, dividend bits shift out as quotient bits shift in
	for (genvar k = 1; k <= QW; k++) begin : g_bit
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [16:0] r2;
			logic [16:0] diff;
			logic        ge;

			assign r2   = {rem_s[k-1][l], quo_s[k-1][l][QW-1]};
			assign diff = r2 - {1'b0, vdc};
			assign ge   = r2 >= {1'b0, vdc};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? diff[15:0] : r2[15:0];
					quo_s[k][l] <= {quo_s[k-1][l][QW-2:0], ge};
					neg_s[k][l] <= neg_s[k-1][l];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) side_s[k] <= side_s[k-1];
		end
	end

	// sign fix: negative dividends round toward minus infinity
	logic signed [QW:0] q_c [2];
	logic signed [QW:0] t_s [2];
	side_t              side_out_s;

	for (genvar l = 0; l < 2; l++) begin : g_fix
		logic signed [QW:0] qs;
		logic signed [QW:0] rnz;
		assign qs     = $signed({1'b0, quo_s[QW][l]});
		assign rnz    = $signed({{QW{1'b0}}, (rem_s[QW][l] != 16'd0)});
		assign q_c[l] = neg_s[QW][l] ? (-qs - rnz) : qs;

		always_ff @(posedge clk) begin
			if (en) t_s[l] <= q_c[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en) side_out_s <= side_s[QW];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW + 2; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < QW + 2; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	assign out_vld  = vld_s[QW+1];
	assign t_a      = t_s[0];
	assign t_b      = t_s[1];
	assign out_side = side_out_s;

endmodule

`default_nettype wire

@@ design/svpg_back.sv @@
// Back end: K/L/M/N references, sector routing, carrier compare, output register.
// Depends on svpg_pkg.
`default_nettype none

module svpg_back #(
	parameter int QW = 36
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [15:0]         ts,
	input  wire logic                in_vld,
	input  wire logic signed [QW:0]  t_a,
	input  wire logic signed [QW:0]  t_b,
	input  svpg_pkg::side_t          in_side,
	output logic                     out_vld,
	output logic [5:0]               gates,
	output logic [2:0]               sector,
	output logic signed [31:0]       ref_a,
	output logic signed [31:0]       ref_b,
	output logic signed [31:0]       ref_c
);
	import svpg_pkg::*;

	localparam int SW = (QW + 3 > 34) ? QW + 3 : 34;

	// stage 1: quarter-period references, wrapped to 32 bits
	logic signed [SW-1:0] ts_e, ta_e, tb_e, k_c, l_c, m_c, n_c;
	logic signed [31:0]   k_w, l_w, m_w, n_w, ra_c, rb_c, rc_c;
	logic signed [31:0]   ra_s1, rb_s1, rc_s1;
	side_t                side_s1;
	logic                 vld_s1;

	assign ts_e = SW'($signed({1'b0, ts}));
	assign ta_e = SW'(t_a);
	assign tb_e = SW'(t_b);
	assign k_c  = ts_e - ta_e - tb_e;
	assign l_c  = ts_e + ta_e - tb_e;
	assign m_c  = ts_e - ta_e + tb_e;
	assign n_c  = ts_e + ta_e + tb_e;
	assign k_w  = k_c[33:2];
	assign l_w  = l_c[33:2];
	assign m_w  = m_c[33:2];
	assign n_w  = n_c[33:2];

	always_comb begin
		case (in_side.sector)
			SECT_0:  begin ra_c = k_w; rb_c = l_w; rc_c = n_w; end
			SECT_1:  begin ra_c = m_w; rb_c = k_w; rc_c = n_w; end
			SECT_2:  begin ra_c = n_w; rb_c = k_w; rc_c = l_w; end
			SECT_3:  begin ra_c = n_w; rb_c = m_w; rc_c = k_w; end
			SECT_4:  begin ra_c = l_w; rb_c = n_w; rc_c = k_w; end
			default: begin ra_c = k_w; rb_c = n_w; rc_c = m_w; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_s1   <= ra_c;
			rb_s1   <= rb_c;
			rc_s1   <= rc_c;
			side_s1 <= in_side;
		end
	end

	// stage 2: carrier compare into the output register
	logic signed [32:0] car_e;
	logic [2:0]         up_c;
	logic [5:0]         gates_s2;
	logic [2:0]         sector_s2;
	logic signed [31:0] ra_s2, rb_s2, rc_s2;
	logic               vld_s2;

	assign car_e   = $signed({17'd0, side_s1.carrier});
	assign up_c[0] = car_e > 33'(ra_s1);
	assign up_c[1] = car_e > 33'(rb_s1);
	assign up_c[2] = car_e > 33'(rc_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			gates_s2  <= {~up_c, up_c};
			sector_s2 <= side_s1.sector;
			ra_s2     <= ra_s1;
			rb_s2     <= rb_s1;
			rc_s2     <= rc_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_vld = vld_s2;
	assign gates   = gates_s2;
	assign sector  = sector_s2;
	assign ref_a   = ra_s2;
	assign ref_b   = rb_s2;
	assign ref_c   = rc_s2;

endmodule

`default_nettype wire

@@ design/space_vector_pwm_gates.sv @@
// Space vector PWM gate generator, seven-segment scheme, top level.
// Depends on svpg_pkg, svpg_front, svpg_div, svpg_back and assert_macros.svh.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    volt_alpha, volt_beta, carrier_count
//   output   out        out_valid / out_stall  gate_bits, sector_index, ref_phase_a/b/c
//   config   in         cfg_wr_en              cfg_index, cfg_data
//
// One word per clock sustained while the output is not stalled; 3 front stages,
// VOLT_WIDTH + 22 divider stages (magnitude, one per quotient bit, sign fix), 2 back stages.
// The pipeline advances as a whole; it stalls only when the output register is full
// and out_stall is high.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`default_nettype none

module space_vector_pwm_gates #(
	parameter int VOLT_WIDTH      = 16,
	parameter int SQRT3_FRAC_BITS = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_index,
	input  wire logic [15:0]                   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [VOLT_WIDTH-1:0]  volt_alpha,
	input  wire logic signed [VOLT_WIDTH-1:0]  volt_beta,
	input  wire logic [15:0]                   carrier_count,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [5:0]                         gate_bits,
	output logic [2:0]                         sector_index,
	output logic signed [31:0]                 ref_phase_a,
	output logic signed [31:0]                 ref_phase_b,
	output logic signed [31:0]                 ref_phase_c
);
	import svpg_pkg::*;
	`include "assert_macros.svh"

	localparam int QW = VOLT_WIDTH + 20;

	// configuration registers; a zero DC voltage is stored as one
	logic [15:0] vdc_q, ts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vdc_q <= 16'd32768;
			ts_q  <= 16'd1000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_VDC: vdc_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
				REG_TS:  ts_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance
	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	logic                 f_vld, d_vld;
	logic signed [QW-1:0] f_na, f_nb;
	logic signed [QW:0]   d_ta, d_tb;
	side_t                f_side, d_side;

	svpg_front #(.W(VOLT_WIDTH), .F(SQRT3_FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.alpha   (volt_alpha),
		.beta    (volt_beta),
		.carrier (carrier_count),
		.ts      (ts_q),
		.out_vld (f_vld),
		.num_a   (f_na),
		.num_b   (f_nb),
		.side    (f_side)
	);

	svpg_div #(.QW(QW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vdc      (vdc_q),
		.in_vld   (f_vld),
		.num_a    (f_na),
		.num_b    (f_nb),
		.in_side  (f_side),
		.out_vld  (d_vld),
		.t_a      (d_ta),
		.t_b      (d_tb),
		.out_side (d_side)
	);

	svpg_back #(.QW(QW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ts      (ts_q),
		.in_vld  (d_vld),
		.t_a     (d_ta),
		.t_b     (d_tb),
		.in_side (d_side),
		.out_vld (out_valid),
		.gates   (gate_bits),
		.sector  (sector_index),
		.ref_a   (ref_phase_a),
		.ref_b   (ref_phase_b),
		.ref_c   (ref_phase_c)
	);

	// checks
	`SVPG_CHECK(a_vdc_nonzero, vdc_q != 16'd0, "DC voltage register holds zero")
	`SVPG_IMPLY(a_no_stall_empty, !out_valid, !in_stall, "input stalled with empty output")
	`SVPG_IMPLY(a_sector_range, out_valid, sector_index <= SECT_5, "sector out of range")
	`SVPG_IMPLY(a_gate_compl, out_valid, gate_bits[5:3] == ~gate_bits[2:0], "gates not complementary")

endmodule

`default_nettype wire

@@ dv/space_vector_pwm_gates_test.sv @@
// Testbench for space_vector_pwm_gates: random and directed alpha/beta samples against
// an in-bench model of sector, reference and gate logic. Depends on svpg_pkg and the RTL.
`timescale 1ns / 100ps

module space_vector_pwm_gates_test;
	import svpg_pkg::*;

	localparam longint SQRT3_Q14 = 28378;
	localparam longint F_SCALE   = 16384;
	localparam int     SETTLE    = 60;
	localparam int     LIMIT     = 400000;

	typedef struct {
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic [15:0]        carrier;
	} sample_t;

	typedef struct {
		logic [5:0]         gates;
		logic [2:0]         sector;
		logic signed [31:0] ref_a;
		logic signed [31:0] ref_b;
		logic signed [31:0] ref_c;
	} gate_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = REG_VDC;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] volt_alpha = '0;
	logic signed [15:0] volt_beta = '0;
	logic [15:0] carrier_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] gate_bits;
	logic [2:0] sector_index;
	logic signed [31:0] ref_phase_a, ref_phase_b, ref_phase_c;

	sample_t    pending_samples[$];
	gate_word_t expected_gates[$];
	int         fail_count = 0;
	int         cycle_count = 0;
	longint     vdc_reg = 32768;
	longint     ts_reg = 1000;
	bit         allow_idle = 1'b1;
	bit         long_hold_go = 1'b0;
	bit         long_hold_done = 1'b0;
	int         hold_cycles = 0;
	int         send_gap = 0;
	int         recv_gap = 0;

	space_vector_pwm_gates i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// floor division, divisor positive
	function automatic longint floor_div(input longint n, input longint d);
		longint q;
		begin
			q = n / d;
			if ((n % d != 0) && (n < 0)) q = q - 1;
			return q;
		end
	endfunction

	function automatic gate_word_t predict_gates(input sample_t s);
		gate_word_t r;
		longint a, b, bs, p, vdc, d, xn, yn, zn, ta_n, tb_n, ta, tb;
		int k, l, m, n;
		int refs[3];
		begin
			a = s.alpha;
			b = s.beta;
			bs = b * F_SCALE;
			p = SQRT3_Q14 * a;
			vdc = (vdc_reg == 0) ? 1 : vdc_reg;
			d = vdc * 2 * F_SCALE;
			if (b >= 0 && bs <= p) r.sector = SECT_0;
			else if (b >= 0 && ((a >= 0 && bs >= p) || (a < 0 && bs >= -p))) r.sector = SECT_1;
			else if (b >= 0 && bs <= -p) r.sector = SECT_2;
			else if (b <= 0 && bs >= p) r.sector = SECT_3;
			else if (b <= 0 && ((a <= 0 && bs <= p) || (a > 0 && bs <= -p))) r.sector = SECT_4;
			else r.sector = SECT_5;
			xn = 2 * SQRT3_Q14 * b;
			yn = 3 * a * F_SCALE + SQRT3_Q14 * b;
			zn = -3 * a * F_SCALE + SQRT3_Q14 * b;
			case (r.sector)
				SECT_0: begin ta_n = -zn; tb_n = xn; end
				SECT_1: begin ta_n = yn; tb_n = zn; end
				SECT_2: begin ta_n = xn; tb_n = -yn; end
				SECT_3: begin ta_n = zn; tb_n = -xn; end
				SECT_4: begin ta_n = -yn; tb_n = -zn; end
				default: begin ta_n = -xn; tb_n = yn; end
			endcase
			ta = floor_div(ta_n * ts_reg, d);
			tb = floor_div(tb_n * ts_reg, d);
			// references wrap to 32 bits, no overmodulation clamp
			k = int'(floor_div(ts_reg - ta - tb, 4));
			l = int'(floor_div(ts_reg + ta - tb, 4));
			m = int'(floor_div(ts_reg - ta + tb, 4));
			n = int'(floor_div(ts_reg + ta + tb, 4));
			case (r.sector)
				SECT_0: refs = '{k, l, n};
				SECT_1: refs = '{m, k, n};
				SECT_2: refs = '{n, k, l};
				SECT_3: refs = '{n, m, k};
				SECT_4: refs = '{l, n, k};
				default: refs = '{k, n, m};
			endcase
			r.gates = '0;
			for (int i = 0; i < 3; i++) begin
				if (longint'(s.carrier) > longint'(refs[i])) r.gates[i] = 1'b1;
				else r.gates[i+3] = 1'b1;
			end
			r.ref_a = refs[0];
			r.ref_b = refs[1];
			r.ref_c = refs[2];
			return r;
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		begin
			$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
				cycle_count);
			fail_count++;
		end
	endtask

	// sender: presents queued words, random idle bursts
	always @(posedge clk) begin
		sample_t s;
		if (in_valid && !in_stall) begin
			s.alpha = volt_alpha;
			s.beta = volt_beta;
			s.carrier = carrier_count;
			expected_gates.push_back(predict_gates(s));
		end
		if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_samples.size() == 0 || !arst_n) begin
				in_valid <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 5) == 0) begin
				send_gap <= $urandom_range(0, 3);
				in_valid <= 1'b0;
			end else begin
				s = pending_samples.pop_front();
				volt_alpha <= s.alpha;
				volt_beta <= s.beta;
				carrier_count <= s.carrier;
				in_valid <= 1'b1;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (long_hold_go && !long_hold_done) begin
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles >= 200) long_hold_done <= 1'b1;
		end
	end

	// receiver: checks each accepted word against the oldest prediction
	always @(posedge clk) begin
		gate_word_t e;
		if (out_valid && !out_stall) begin
			if (expected_gates.size() == 0) begin
				$display("unexpected output word at cycle %0d", cycle_count);
				fail_count++;
			end else begin
				e = expected_gates.pop_front();
				if (gate_bits !== e.gates) report_mismatch("gate_bits", gate_bits, e.gates);
				if (sector_index !== e.sector)
					report_mismatch("sector_index", sector_index, e.sector);
				if (ref_phase_a !== e.ref_a) report_mismatch("ref_phase_a", ref_phase_a, e.ref_a);
				if (ref_phase_b !== e.ref_b) report_mismatch("ref_phase_b", ref_phase_b, e.ref_b);
				if (ref_phase_c !== e.ref_c) report_mismatch("ref_phase_c", ref_phase_c, e.ref_c);
			end
		end
		if (long_hold_go && !long_hold_done) begin
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_stall <= 1'b1;
		end else if (allow_idle && $urandom_range(0, 5) == 0) begin
			recv_gap <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic sample_t make_sample(input int a, input int b, input int c);
		sample_t s;
		begin
			s.alpha = 16'(a);
			s.beta = 16'(b);
			s.carrier = 16'(c);
			return s;
		end
	endfunction

	// full-range values half the time, small ones otherwise so references land inside the carrier range
	function automatic sample_t random_sample();
		sample_t s;
		begin
			if ($urandom_range(0, 1) == 0) begin
				s.alpha = 16'($urandom);
				s.beta = 16'($urandom);
			end else begin
				s.alpha = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
				s.beta = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
			end
			s.carrier = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1100));
			return s;
		end
	endfunction

	task automatic drain_and_settle();
		begin
			while (pending_samples.size() != 0 || in_valid || expected_gates.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);
		end
	endtask

	task automatic write_regs(input int vdc, input int ts);
		begin
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_VDC;
			cfg_data <= 16'(vdc);
			@(posedge clk);
			cfg_index <= REG_TS;
			cfg_data <= 16'(ts);
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			vdc_reg = vdc;
			ts_reg = ts;
		end
	endtask

	task automatic run_random(input int count);
		begin
			repeat (count) pending_samples.push_back(random_sample());
			drain_and_settle();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, axis and sector boundary points, carrier ends
		pending_samples.push_back(make_sample(0, 0, 0));
		pending_samples.push_back(make_sample(0, 0, 65535));
		pending_samples.push_back(make_sample(32767, 0, 250));
		pending_samples.push_back(make_sample(-32768, 0, 250));
		pending_samples.push_back(make_sample(0, 32767, 500));
		pending_samples.push_back(make_sample(0, -32768, 500));
		pending_samples.push_back(make_sample(32767, 32767, 65535));
		pending_samples.push_back(make_sample(-32768, -32768, 0));
		pending_samples.push_back(make_sample(32767, -32768, 300));
		pending_samples.push_back(make_sample(-32768, 32767, 300));
		pending_samples.push_back(make_sample(1000, 1732, 400));
		pending_samples.push_back(make_sample(1000, 1733, 400));
		pending_samples.push_back(make_sample(-1000, 1732, 400));
		pending_samples.push_back(make_sample(-1000, 1733, 400));
		pending_samples.push_back(make_sample(1000, -1732, 400));
		pending_samples.push_back(make_sample(-1000, -1733, 400));
		pending_samples.push_back(make_sample(500, 100, 200));
		pending_samples.push_back(make_sample(-500, 100, 200));
		pending_samples.push_back(make_sample(500, -100, 200));
		pending_samples.push_back(make_sample(-500, -100, 200));
		pending_samples.push_back(make_sample(-1, -1, 1));
		drain_and_settle();

		// default registers, with one long receiver hold-off while the sender keeps going
		long_hold_go = 1'b1;
		run_random(150);

		// overmodulation: smallest voltage, longest period
		write_regs(1, 65535);
		run_random(100);
		write_regs(65535, 1);
		run_random(100);
		// zero voltage and zero period
		write_regs(0, 0);
		run_random(60);
		write_regs(65535, 65535);
		run_random(100);
		write_regs($urandom_range(1, 65535), $urandom_range(1, 65535));
		run_random(120);
		write_regs($urandom_range(100, 4000), $urandom_range(500, 3000));
		run_random(120);

		// no idling at the end
		allow_idle = 1'b0;
		write_regs(32768, 1000);
		run_random(100);

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/svpg_pkg.sv
design/svpg_front.sv
design/svpg_div.sv
design/svpg_back.sv
design/space_vector_pwm_gates.sv
dv/space_vector_pwm_gates_test.sv
